// File: sv/bres_pkg.sv
// Shared types and constants for the line rasterizer.
// Holds the command codes, frame store geometry and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package bres_pkg;

  localparam int OP_W = 2;

  localparam logic [OP_W-1:0] OP_LINE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL = 2'd2;

  localparam int STORE_BYTES = 1024;
  localparam int STORE_AW    = 10;
  localparam int COORD_W     = 16;
  localparam int PAGE_SHIFT  = 3;  // eight rows to a page

  localparam logic [7:0] FULL_BYTE  = 8'hFF;
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  typedef enum logic [7:0] {
    S_SWEEP  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_DIFF   = 8'b0000_1000,
    S_ORDER  = 8'b0001_0000,
    S_STEP   = 8'b0010_0000,
    S_WRITE  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

endpackage

// File: sv/bresenham_line_rasterizer.sv
// Bresenham line engine over a 1024-byte paged one-bit frame store.
// Line: after acceptance, DIFF and ORDER set up; then each major-axis step is STEP alone for a
// clipped pixel, or STEP then WRITE for a drawn pixel (read-modify-write); then RESULT posts.
// Fill: accept, sweep the store at one store byte per cycle, then post. Read: accept, READ, post.
// One command at a time; in_stall stays high from acceptance until the result is posted.
// Reset starts a zeroing sweep of every store byte; no command is taken until it ends.
`timescale 1ns / 1ps

module bresenham_line_rasterizer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bres_pkg::OP_W-1:0]          operation,
  input  logic signed [bres_pkg::COORD_W-1:0] start_x,
  input  logic signed [bres_pkg::COORD_W-1:0] start_y,
  input  logic signed [bres_pkg::COORD_W-1:0] end_x,
  input  logic signed [bres_pkg::COORD_W-1:0] end_y,
  input  logic                               pixel_on,
  input  logic [bres_pkg::STORE_AW-1:0]      byte_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         read_byte
);

  import bres_pkg::*;

  localparam int WBITS  = $clog2(SCREEN_WIDTH + 1);
  localparam int PAGE_W = COORD_W - PAGE_SHIFT;
  localparam int PROD_W = PAGE_W + WBITS;
  localparam logic [WBITS-1:0]   WIDTH_VAL  = WBITS'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] WIDTH_LIM  = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] HEIGHT_LIM = COORD_W'(SCREEN_HEIGHT);
  localparam logic [PROD_W:0]    STORE_LIM  = (PROD_W+1)'(STORE_BYTES);

  state_t state;

  // frame store
  logic [7:0] mem [STORE_BYTES];
  logic [7:0] mem_rdata;
  logic [STORE_AW-1:0] mem_raddr;
  logic [STORE_AW-1:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic mem_we;

  // command registers
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic on;
  logic [COORD_W-1:0] adx, ady;

  // stepping registers
  logic steep;
  logic step_up;
  logic signed [COORD_W-1:0] u, v;
  logic [COORD_W-1:0] dx, dy, cnt;
  logic signed [COORD_W+1:0] err;
  logic [STORE_AW-1:0] pix_addr;
  logic [PAGE_SHIFT-1:0] bit_sel;

  logic [STORE_AW-1:0] sweep_cnt;
  logic [7:0] fill_byte;
  logic fill_reply;
  logic [7:0] result_byte;

  // difference stage
  logic signed [COORD_W:0] ddx, ddy;
  logic [COORD_W:0] ddx_abs, ddy_abs;

  // ordering stage
  logic steep_c, swap_c;
  logic signed [COORD_W-1:0] maj_a, maj_b, min_a, min_b, v_end_c;
  logic [COORD_W-1:0] dx_c;

  // pixel stage
  logic signed [COORD_W-1:0] px, py;
  logic on_screen;
  logic [PAGE_W-1:0] page;
  logic [PROD_W-1:0] pix_prod;
  logic [PROD_W:0] pix_lin;
  logic draw_pix;

  // error update
  logic signed [COORD_W+1:0] err_sub;
  logic signed [COORD_W+1:0] err_next;
  logic step_minor;

  logic [7:0] bit_mask;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ddx     = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
    ddy     = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
    ddx_abs = ddx[COORD_W] ? (COORD_W+1)'(-ddx) : (COORD_W+1)'(ddx);
    ddy_abs = ddy[COORD_W] ? (COORD_W+1)'(-ddy) : (COORD_W+1)'(ddy);
  end

  always_comb begin
    steep_c = (ady > adx);
    maj_a   = steep_c ? ay : ax;
    maj_b   = steep_c ? by : bx;
    min_a   = steep_c ? ax : ay;
    min_b   = steep_c ? bx : by;
    swap_c  = (maj_a > maj_b);
    v_end_c = swap_c ? min_a : min_b;
    dx_c    = steep_c ? ady : adx;
  end

  always_comb begin
    px        = steep ? v : u;
    py        = steep ? u : v;
    on_screen = !px[COORD_W-1] && !py[COORD_W-1] &&
                (px < WIDTH_LIM) && (py < HEIGHT_LIM);
    page      = PAGE_W'(py[COORD_W-1:PAGE_SHIFT]);
    pix_prod  = PROD_W'(page) * PROD_W'(WIDTH_VAL);
    pix_lin   = {1'b0, pix_prod} + (PROD_W+1)'(px);
    draw_pix  = on_screen && (pix_lin < STORE_LIM);
  end

  always_comb begin
    err_sub    = err - (COORD_W+2)'(dy);
    step_minor = err_sub[COORD_W+1];
    err_next   = step_minor ? err_sub + (COORD_W+2)'(dx) : err_sub;
  end

  always_comb begin
    bit_mask  = 8'(1) << bit_sel;
    mem_raddr = (state == S_IDLE) ? byte_index : pix_lin[STORE_AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = sweep_cnt;
    mem_wdata = fill_byte;
    if (state == S_SWEEP) begin
      mem_we = 1'b1;
    end else if (state == S_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = pix_addr;
      mem_wdata = on ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      fill_byte  <= EMPTY_BYTE;
      fill_reply <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // post a result when the output register is free, drop it once taken
      if (state == S_RESULT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == '1) begin
            state <= fill_reply ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            ax          <= start_x;
            ay          <= start_y;
            bx          <= end_x;
            by          <= end_y;
            on          <= pixel_on;
            result_byte <= EMPTY_BYTE;
            case (operation)
              OP_LINE: state <= S_DIFF;
              OP_READ: state <= S_READ;
              OP_FILL: begin
                fill_byte  <= pixel_on ? FULL_BYTE : EMPTY_BYTE;
                fill_reply <= 1'b1;
                sweep_cnt  <= '0;
                state      <= S_SWEEP;
              end
              default: state <= S_RESULT;
            endcase
          end
        end
        S_READ: begin
          result_byte <= mem_rdata;
          state       <= S_RESULT;
        end
        S_DIFF: begin
          adx   <= COORD_W'(ddx_abs);
          ady   <= COORD_W'(ddy_abs);
          state <= S_ORDER;
        end
        S_ORDER: begin
          steep   <= steep_c;
          u       <= swap_c ? maj_b : maj_a;
          v       <= swap_c ? min_b : min_a;
          step_up <= (swap_c ? min_b : min_a) < v_end_c;
          dx      <= dx_c;
          dy      <= steep_c ? adx : ady;
          cnt     <= dx_c;
          err     <= (COORD_W+2)'(dx_c >> 1);
          state   <= S_STEP;
        end
        S_STEP: begin
          if (draw_pix) begin
            // read issued this cycle; modify and write back next cycle
            pix_addr <= pix_lin[STORE_AW-1:0];
            bit_sel  <= py[PAGE_SHIFT-1:0];
            state    <= S_WRITE;
          end else begin
            err <= err_next;
            u   <= u + 1'b1;
            if (step_minor) begin
              v <= step_up ? v + 1'b1 : v - 1'b1;
            end
            cnt <= cnt - 1'b1;
            if (cnt == '0) begin
              state <= S_RESULT;
            end
          end
        end
        S_WRITE: begin
          err <= err_next;
          u   <= u + 1'b1;
          if (step_minor) begin
            v <= step_up ? v + 1'b1 : v - 1'b1;
          end
          cnt <= cnt - 1'b1;
          state <= (cnt == '0) ? S_RESULT : S_STEP;
        end
        S_RESULT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            read_byte  <= result_byte;
            fill_reply <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sim/tb_bresenham_line_rasterizer.sv
// Self-checking testbench for bresenham_line_rasterizer: draws, fills and reads
// the paged frame store and predicts every read_byte with a model of its own.
// Depends on bres_pkg and the rasterizer RTL only.
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;
  import bres_pkg::*;

  localparam int SCREEN_W = 128;
  localparam int SCREEN_H = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM = 1900;
  localparam int CYCLE_LIMIT = 4_000_000;

  // Frame store prediction and the queue of read_byte values still owed by the block.
  class frame_predictor;
    logic [7:0] frame [STORE_BYTES];
    logic [7:0] expected_bytes [$];
    int unsigned mismatches;

    function new();
      foreach (frame[i]) frame[i] = EMPTY_BYTE;
      mismatches = 0;
    endfunction

    function void plot(int x, int y, bit on);
      int addr;
      if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return;
      addr = (y >> PAGE_SHIFT) * SCREEN_W + x;
      if (addr >= STORE_BYTES) return;
      frame[addr][y & 7] = on;
    endfunction

    function void rasterize(int ax, int ay, int bx, int by, bit on);
      int t, dx, dy, err, step, v;
      bit steep;
      steep = ((by < ay) ? ay - by : by - ay) > ((bx < ax) ? ax - bx : bx - ax);
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = (by < ay) ? ay - by : by - ay;
      err = dx / 2;
      step = (ay < by) ? 1 : -1;
      v = ay;
      for (int u = ax; u <= bx; u++) begin
        if (steep) plot(v, u, on);
        else plot(u, v, on);
        err -= dy;
        if (err < 0) begin
          v += step;
          err += dx;
        end
      end
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] sx, sy,
                               ex, ey, logic on, logic [STORE_AW-1:0] idx);
      logic [7:0] rb;
      rb = EMPTY_BYTE;
      case (op)
        OP_LINE: rasterize(int'(sx), int'(sy), int'(ex), int'(ey), on);
        OP_READ: rb = frame[idx];
        OP_FILL: foreach (frame[i]) frame[i] = on ? FULL_BYTE : EMPTY_BYTE;
        default: ;
      endcase
      expected_bytes.push_back(rb);
    endfunction

    function void check_read_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        $error("read_byte: unexpected transaction, actual %02h", got);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        $error("read_byte: expected %02h, actual %02h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operation = OP_LINE;
  logic signed [COORD_W-1:0] start_x = '0;
  logic signed [COORD_W-1:0] start_y = '0;
  logic signed [COORD_W-1:0] end_x = '0;
  logic signed [COORD_W-1:0] end_y = '0;
  logic pixel_on = 1'b0;
  logic [STORE_AW-1:0] byte_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] read_byte;

  frame_predictor sb;
  bit quiet = 1'b0;
  int stall_left = 0;
  int unsigned cycles = 0;

  bresenham_line_rasterizer #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .pixel_on  (pixel_on),
    .byte_index(byte_index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_byte (read_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each transaction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_read_byte(read_byte);
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= quiet ? 0 : pick_gap();
      end
    end
  end

  task automatic send_command(logic [OP_W-1:0] op, int sx, int sy, int ex, int ey,
                              logic on, logic [STORE_AW-1:0] idx);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= op;
    start_x <= sx[COORD_W-1:0];
    start_y <= sy[COORD_W-1:0];
    end_x <= ex[COORD_W-1:0];
    end_y <= ey[COORD_W-1:0];
    pixel_on <= on;
    byte_index <= idx;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, sx[COORD_W-1:0], sy[COORD_W-1:0], ex[COORD_W-1:0],
                    ey[COORD_W-1:0], on, idx);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int r, sx, sy, ex, ey;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners, clipping, wide lines, single points, fills, unused code.
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd0);
    send_command(OP_READ, -1, -1, -1, -1, 1'b1, 10'd1023);
    send_command(OP_LINE, 0, 0, 0, 0, 1'b1, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd0);
    send_command(OP_LINE, 127, 63, 127, 63, 1'b1, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd1023);
    send_command(OP_LINE, -10, 5, 140, 5, 1'b1, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd5);
    send_command(OP_LINE, 3, -20, 3, 90, 1'b1, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd899);
    send_command(OP_LINE, 127, 5, 0, 5, 1'b0, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd3);
    send_command(OP_LINE, -32768, 20, 32767, 20, 1'b1, 10'd0);
    send_command(OP_LINE, 32767, -32768, -32768, 32767, 1'b1, 10'd0);
    send_command(OP_LINE, 60, -32768, 61, 32767, 1'b1, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd316);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd572);
    send_command(OP_UNUSED, -32768, 32767, 12, 7, 1'b1, 10'd512);
    send_command(OP_FILL, 0, 0, 0, 0, 1'b1, 10'd0);
    send_command(OP_LINE, 63, 63, 0, 0, 1'b0, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd700);
    send_command(OP_FILL, 0, 0, 0, 0, 1'b0, 10'd0);
    send_command(OP_READ, 0, 0, 0, 0, 1'b0, 10'd512);
    wait_drained();

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = ((n / 150) % 4) == 2;
      if (n == N_RANDOM / 2) wait_drained();
      r = $urandom_range(0, 999);
      if (r < 560) begin
        // near the screen, short or long, crossing the edges now and then
        sx = int'($urandom_range(0, 159)) - 16;
        sy = int'($urandom_range(0, 95)) - 16;
        if ($urandom_range(0, 1)) begin
          ex = sx + int'($urandom_range(0, 48)) - 24;
          ey = sy + int'($urandom_range(0, 48)) - 24;
        end else begin
          ex = int'($urandom_range(0, 159)) - 16;
          ey = int'($urandom_range(0, 95)) - 16;
        end
        send_command(OP_LINE, sx, sy, ex, ey, $urandom_range(0, 3) != 0,
                     10'($urandom_range(0, 1023)));
      end else if (r < 640) begin
        // short segment anywhere in coordinate space, exercises the high bits cheaply
        sx = int'($urandom_range(0, 65535)) - 32768;
        sy = int'($urandom_range(0, 65535)) - 32768;
        ex = clamp16(sx + int'($urandom_range(0, 64)) - 32);
        ey = clamp16(sy + int'($urandom_range(0, 64)) - 32);
        send_command(OP_LINE, sx, sy, ex, ey, 1'($urandom_range(0, 1)),
                     10'($urandom_range(0, 1023)));
      end else if (r < 643) begin
        send_command(OP_LINE, int'($urandom_range(0, 65535)) - 32768,
                     int'($urandom_range(0, 65535)) - 32768,
                     int'($urandom_range(0, 65535)) - 32768,
                     int'($urandom_range(0, 65535)) - 32768,
                     1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      end else if (r < 668) begin
        send_command(OP_FILL, int'($urandom_range(0, 65535)) - 32768, 0, 0, 0,
                     1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      end else if (r < 678) begin
        send_command(OP_UNUSED, int'($urandom_range(0, 65535)) - 32768,
                     int'($urandom_range(0, 65535)) - 32768, 0, 0,
                     1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      end else begin
        send_command(OP_READ, int'($urandom_range(0, 65535)) - 32768,
                     int'($urandom_range(0, 65535)) - 32768, 0, 0,
                     1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.expected_bytes.size() != 0)
      $error("read_byte: %0d transactions never arrived", sb.expected_bytes.size());
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bres_pkg.sv
sv/bresenham_line_rasterizer.sv
sim/tb_bresenham_line_rasterizer.sv
